### sv/bwtg_pkg.sv
// Shared widths, register indexes, constants, payload types and helpers of the brick texel unit.
package bwtg_pkg;

    // Field and datapath widths.
    localparam int COORD_W    = 6;
    localparam int DIM_W      = 7;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 7;
    localparam int COLOR_W    = 24;
    localparam int CH_W       = 8;
    localparam int LIGHT_W    = 19;
    localparam int NOISE_W    = 16;
    localparam int NUM_W      = 36;
    localparam int FRAC_W     = 32;
    localparam int PROD_W     = FRAC_W + CH_W;
    localparam int HASH_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BRK_W       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRK_H       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_JOINT_COLOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BRK_RGB     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_BASE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_VARY  = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [DIM_W-1:0]          RST_BRK_W       = 7'd16;
    localparam logic [DIM_W-1:0]          RST_BRK_H       = 7'd8;
    localparam logic [COLOR_W-1:0]        RST_JOINT_COLOR = 24'h808080;
    localparam logic [COLOR_W-1:0]        RST_BRK_RGB     = 24'hA0522D;
    localparam logic signed [LIGHT_W-1:0] RST_LIGHT_BASE  = 19'sd45875;
    localparam logic signed [LIGHT_W-1:0] RST_LIGHT_VARY  = 19'sd19661;

    // Hash multipliers.
    localparam logic [HASH_W-1:0] HASH_MX  = 32'd374761393;
    localparam logic [HASH_W-1:0] HASH_MY  = 32'd668265263;
    localparam logic [HASH_W-1:0] HASH_MIX = 32'd1274126177;

    // Light denominator 65536 * 65535 and the noise full scale.
    localparam logic signed [NUM_W-1:0] LIGHT_DEN = 36'sd4294901760;
    localparam logic [NOISE_W:0]        NOISE_MAX = 17'd65535;

    // Configuration bundle seen by the locator and shader stages.
    typedef struct packed {
        logic [DIM_W-1:0]          brk_w;
        logic [DIM_W-1:0]          brk_h;
        logic [COLOR_W-1:0]        joint_color;
        logic [COLOR_W-1:0]        brk_rgb;
        logic signed [LIGHT_W-1:0] light_base;
        logic signed [LIGHT_W-1:0] light_vary;
    } t_cfg;

    // Brick cell of a texel and its mortar flag.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             joint;
    } t_cell;

    // Per-brick noise and the mortar flag.
    typedef struct packed {
        logic [NOISE_W-1:0] noise;
        logic               joint;
    } t_noise;

    // A zero brick dimension behaves as one.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        return (d == '0) ? DIM_W'(1) : d;
    endfunction

    // One restoring division step: quotient bit on top, new remainder below.
    // The incoming remainder is always below the divisor.
    function automatic logic [DIM_W:0] div_step(input logic [DIM_W-1:0] rem,
                                                input logic             b,
                                                input logic [DIM_W-1:0] d);
        logic [DIM_W:0] t;
        logic [DIM_W:0] dd;
        t  = {rem, b};
        dd = {1'b0, d};
        if (t >= dd) begin
            return {1'b1, DIM_W'(t - dd)};
        end
        return {1'b0, DIM_W'(t)};
    endfunction

    // floor(p / (65536 * 65535)) for a product below 255 times the denominator.
    // The quotient estimate from the top byte is short by at most one.
    function automatic logic [CH_W-1:0] scale_div(input logic [PROD_W-1:0] p);
        logic [PROD_W-17:0] q;
        logic [CH_W-1:0]    e;
        logic [NOISE_W:0]   r;
        q = p[PROD_W-1:16];
        e = q[PROD_W-17:16];
        r = {1'b0, q[15:0]} + {{(NOISE_W+1-CH_W){1'b0}}, e};
        if (r >= NOISE_MAX) begin
            return e + CH_W'(1);
        end
        return e;
    endfunction

endpackage

### sv/bwtg_ifs.sv
// Handshake channels of the brick texel unit: coordinates, colors and configuration writes.
interface bwtg_coord_if;
    logic                         valid;
    logic                         ready;
    logic [bwtg_pkg::COORD_W-1:0] tex_x;
    logic [bwtg_pkg::COORD_W-1:0] tex_y;

    modport source (output valid, output tex_x, output tex_y, input ready);
    modport sink (input valid, input tex_x, input tex_y, output ready);
endinterface

interface bwtg_color_if;
    logic                         valid;
    logic                         ready;
    logic [bwtg_pkg::COLOR_W-1:0] texel_color;

    modport source (output valid, output texel_color, input ready);
    modport sink (input valid, input texel_color, output ready);
endinterface

interface bwtg_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bwtg_pkg::CFG_IDX_W-1:0]  index;
    logic [bwtg_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### sv/bwtg_coord.sv
// Four-stage brick locator: row and column by pipelined restoring division, mortar detection.
module bwtg_coord (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bwtg_pkg::t_cfg               i_cfg,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [bwtg_pkg::COORD_W-1:0] i_tex_x,
    input  logic [bwtg_pkg::COORD_W-1:0] i_tex_y,
    output logic                         o_valid,
    input  logic                         i_ready,
    output bwtg_pkg::t_cell              o_cell
);
    localparam int NSTG = 4;
    localparam int DW   = bwtg_pkg::DIM_W;

    logic [NSTG-1:0] r_v;
    logic [NSTG:0]   stg_en;
    logic [DW-1:0]   w_eff;
    logic [DW-1:0]   h_eff;

    // Stage 1: upper three row quotient bits.
    logic [DW:0]    a0, a1, a2;
    logic [2:0]     r_s1_yq;
    logic [DW-1:0]  r_s1_yrem;
    logic [2:0]     r_s1_ylo;
    logic [bwtg_pkg::COORD_W-1:0] r_s1_x;

    // Stage 2: lower row quotient bits, shifted column position.
    logic [DW:0]    b0, b1, b2;
    logic [bwtg_pkg::ROW_W-1:0] n_s2_row;
    logic [bwtg_pkg::COORD_W-1:0] shift;
    logic [bwtg_pkg::ROW_W-1:0] r_s2_row;
    logic           r_s2_yjoint;
    logic [DW-1:0]  r_s2_sx;

    // Stage 3: upper four column quotient bits.
    logic [DW:0]    c0, c1, c2, c3;
    logic [3:0]     r_s3_cq;
    logic [DW-1:0]  r_s3_crem;
    logic [2:0]     r_s3_sxlo;
    logic [bwtg_pkg::ROW_W-1:0] r_s3_row;
    logic           r_s3_yjoint;

    // Stage 4: lower column quotient bits and the mortar decision.
    logic [DW:0]    d0, d1, d2;
    bwtg_pkg::t_cell n_s4_cell;
    bwtg_pkg::t_cell r_s4_cell;

    assign w_eff = bwtg_pkg::eff_dim(i_cfg.brk_w);
    assign h_eff = bwtg_pkg::eff_dim(i_cfg.brk_h);

    // A stage loads when it is empty or the one after it moves.
    always_comb begin
        stg_en[NSTG] = i_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            stg_en[k] = ~r_v[k] | stg_en[k+1];
        end
    end

    assign o_ready = stg_en[0];
    assign o_valid = r_v[NSTG-1];
    assign o_cell  = r_s4_cell;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (stg_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (stg_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Row division, first half.
    always_comb begin
        a0 = bwtg_pkg::div_step('0, i_tex_y[5], h_eff);
        a1 = bwtg_pkg::div_step(a0[DW-1:0], i_tex_y[4], h_eff);
        a2 = bwtg_pkg::div_step(a1[DW-1:0], i_tex_y[3], h_eff);
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_s1_yq   <= {a0[DW], a1[DW], a2[DW]};
            r_s1_yrem <= a2[DW-1:0];
            r_s1_ylo  <= i_tex_y[2:0];
            r_s1_x    <= i_tex_x;
        end
    end

    // Row division, second half; odd rows shift by half a brick.
    always_comb begin
        b0 = bwtg_pkg::div_step(r_s1_yrem, r_s1_ylo[2], h_eff);
        b1 = bwtg_pkg::div_step(b0[DW-1:0], r_s1_ylo[1], h_eff);
        b2 = bwtg_pkg::div_step(b1[DW-1:0], r_s1_ylo[0], h_eff);
        n_s2_row = {r_s1_yq, b0[DW], b1[DW], b2[DW]};
        shift = n_s2_row[0] ? w_eff[DW-1:1] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[1]) begin
            r_s2_row    <= n_s2_row;
            r_s2_yjoint <= (b2[DW-1:0] == '0);
            r_s2_sx     <= {1'b0, r_s1_x} + {1'b0, shift};
        end
    end

    // Column division, first half.
    always_comb begin
        c0 = bwtg_pkg::div_step('0, r_s2_sx[6], w_eff);
        c1 = bwtg_pkg::div_step(c0[DW-1:0], r_s2_sx[5], w_eff);
        c2 = bwtg_pkg::div_step(c1[DW-1:0], r_s2_sx[4], w_eff);
        c3 = bwtg_pkg::div_step(c2[DW-1:0], r_s2_sx[3], w_eff);
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[2]) begin
            r_s3_cq     <= {c0[DW], c1[DW], c2[DW], c3[DW]};
            r_s3_crem   <= c3[DW-1:0];
            r_s3_sxlo   <= r_s2_sx[2:0];
            r_s3_row    <= r_s2_row;
            r_s3_yjoint <= r_s2_yjoint;
        end
    end

    // Column division, second half; mortar on either boundary.
    always_comb begin
        d0 = bwtg_pkg::div_step(r_s3_crem, r_s3_sxlo[2], w_eff);
        d1 = bwtg_pkg::div_step(d0[DW-1:0], r_s3_sxlo[1], w_eff);
        d2 = bwtg_pkg::div_step(d1[DW-1:0], r_s3_sxlo[0], w_eff);
        n_s4_cell.col   = {r_s3_cq, d0[DW], d1[DW], d2[DW]};
        n_s4_cell.row   = r_s3_row;
        n_s4_cell.joint = r_s3_yjoint | (d2[DW-1:0] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[3]) begin
            r_s4_cell <= n_s4_cell;
        end
    end

endmodule

### sv/bwtg_hash.sv
// Two-stage integer hash of the brick cell, giving 16 bits of noise.
module bwtg_hash (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  bwtg_pkg::t_cell  i_cell,
    output logic             o_valid,
    input  logic             i_ready,
    output bwtg_pkg::t_noise o_noise
);
    localparam int NSTG = 2;
    localparam int HW   = bwtg_pkg::HASH_W;

    logic [NSTG-1:0] r_v;
    logic [NSTG:0]   stg_en;

    logic [HW-1:0]   n_h1_sum;
    logic [HW-1:0]   r_h1_sum;
    logic            r_h1_joint;
    logic [HW-1:0]   mix;
    logic [HW-1:0]   n_h2_prod;
    bwtg_pkg::t_noise r_h2_noise;

    // A stage loads when it is empty or the one after it moves.
    always_comb begin
        stg_en[NSTG] = i_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            stg_en[k] = ~r_v[k] | stg_en[k+1];
        end
    end

    assign o_ready = stg_en[0];
    assign o_valid = r_v[NSTG-1];
    assign o_noise = r_h2_noise;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (stg_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (stg_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Weighted sum of column and row, wrapping at 32 bits.
    assign n_h1_sum = HW'(i_cell.col) * bwtg_pkg::HASH_MX
                    + HW'(i_cell.row) * bwtg_pkg::HASH_MY;

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_h1_sum   <= n_h1_sum;
            r_h1_joint <= i_cell.joint;
        end
    end

    // Xor-shift, then the mixing multiply; the top half is the noise.
    assign mix       = r_h1_sum ^ (r_h1_sum >> 13);
    assign n_h2_prod = mix * bwtg_pkg::HASH_MIX;

    always_ff @(posedge i_clk) begin
        if (stg_en[1]) begin
            r_h2_noise.noise <= n_h2_prod[HW-1:HW-bwtg_pkg::NOISE_W];
            r_h2_noise.joint <= r_h1_joint;
        end
    end

endmodule

### sv/bwtg_shade.sv
// Four-stage shader: light factor, clamp, channel multiplies, scaling and color select.
module bwtg_shade (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bwtg_pkg::t_cfg               i_cfg,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  bwtg_pkg::t_noise             i_noise,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [bwtg_pkg::COLOR_W-1:0] o_color
);
    localparam int NSTG = 4;
    localparam int NW   = bwtg_pkg::NUM_W;
    localparam int FW   = bwtg_pkg::FRAC_W;
    localparam int PW   = bwtg_pkg::PROD_W;
    localparam int CW   = bwtg_pkg::CH_W;

    logic [NSTG-1:0] r_v;
    logic [NSTG:0]   stg_en;

    // Stage 1 signals.
    logic signed [NW-1:0] base_term;
    logic signed [NW-1:0] vary_term;
    logic signed [NW-1:0] r_l1_num;
    logic                 r_l1_joint;

    // Stage 2 signals.
    logic [FW-1:0]        r_l2_frac;
    logic                 r_l2_zero;
    logic                 r_l2_full;
    logic                 r_l2_joint;

    // Stage 3 signals.
    logic [PW-1:0]        r_l3_pr;
    logic [PW-1:0]        r_l3_pg;
    logic [PW-1:0]        r_l3_pb;
    logic                 r_l3_zero;
    logic                 r_l3_full;
    logic                 r_l3_joint;

    // Stage 4 signals.
    logic [CW-1:0]        ch_r, ch_g, ch_b;
    logic [bwtg_pkg::COLOR_W-1:0] n_l4_color;
    logic [bwtg_pkg::COLOR_W-1:0] r_l4_color;

    // A stage loads when it is empty or the one after it moves.
    always_comb begin
        stg_en[NSTG] = i_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            stg_en[k] = ~r_v[k] | stg_en[k+1];
        end
    end

    assign o_ready = stg_en[0];
    assign o_valid = r_v[NSTG-1];
    assign o_color = r_l4_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (stg_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (stg_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Light numerator: base * 65535 + vary * noise.
    assign base_term = (NW'(i_cfg.light_base) <<< 16) - NW'(i_cfg.light_base);
    assign vary_term = NW'(i_cfg.light_vary)
                     * $signed({{(NW-bwtg_pkg::NOISE_W){1'b0}}, i_noise.noise});

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_l1_num   <= base_term + vary_term;
            r_l1_joint <= i_noise.joint;
        end
    end

    // Clamp to the range zero to one; inside it the numerator fits 32 bits.
    always_ff @(posedge i_clk) begin
        if (stg_en[1]) begin
            r_l2_frac  <= r_l1_num[FW-1:0];
            r_l2_zero  <= (r_l1_num <= NW'(0));
            r_l2_full  <= (r_l1_num >= bwtg_pkg::LIGHT_DEN);
            r_l2_joint <= r_l1_joint;
        end
    end

    // One 8 by 32 multiply per channel.
    always_ff @(posedge i_clk) begin
        if (stg_en[2]) begin
            r_l3_pr    <= PW'(r_l2_frac) * PW'(i_cfg.brk_rgb[23:16]);
            r_l3_pg    <= PW'(r_l2_frac) * PW'(i_cfg.brk_rgb[15:8]);
            r_l3_pb    <= PW'(r_l2_frac) * PW'(i_cfg.brk_rgb[7:0]);
            r_l3_zero  <= r_l2_zero;
            r_l3_full  <= r_l2_full;
            r_l3_joint <= r_l2_joint;
        end
    end

    // Scale each channel down, apply the clamp, pick mortar or brick.
    always_comb begin
        if (r_l3_zero) begin
            ch_r = '0;
            ch_g = '0;
            ch_b = '0;
        end else if (r_l3_full) begin
            ch_r = i_cfg.brk_rgb[23:16];
            ch_g = i_cfg.brk_rgb[15:8];
            ch_b = i_cfg.brk_rgb[7:0];
        end else begin
            ch_r = bwtg_pkg::scale_div(r_l3_pr);
            ch_g = bwtg_pkg::scale_div(r_l3_pg);
            ch_b = bwtg_pkg::scale_div(r_l3_pb);
        end
        n_l4_color = r_l3_joint ? i_cfg.joint_color : {ch_r, ch_g, ch_b};
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[3]) begin
            r_l4_color <= n_l4_color;
        end
    end

endmodule

### sv/brick_wall_texel_generator_unit.sv
// Top of the brick wall texel generator: configuration registers and three pipeline parts.
//
// Usage: the coordinate channel i_coord carries one texel (tex_x, tex_y) per item; the color
// channel o_color returns its 24-bit texel_color, red in bits 23:16, green 15:8, blue 7:0.
// The configuration channel i_cfg writes register i_cfg.index with i_cfg.data; it is always
// ready, indexes past the light vary register are ignored, and the user must make writes only
// while idle; the block does not enforce it. Throughput is one item per cycle when the
// receiver does not stall. The ten register stages are: four for the row and column
// restoring divisions, two for the hash, four for the light factor, clamp, channel
// multiplies and final scaling, the last of which is the output register.
// Reset (synchronous, active low) empties the pipeline and loads the default brick size,
// colors and light factors. When the receiver stalls, items close up behind the output
// register into any empty stages; i_coord.ready drops only once every stage holds an item,
// and nothing is dropped or repeated.
module brick_wall_texel_generator_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    bwtg_coord_if.sink          i_coord,
    bwtg_color_if.source        o_color,
    bwtg_cfg_if.sink            i_cfg
);
    bwtg_pkg::t_cfg   r_cfg;

    logic             cell_valid;
    logic             cell_ready;
    bwtg_pkg::t_cell  loc;
    logic             noise_valid;
    logic             noise_ready;
    bwtg_pkg::t_noise noise;

    // Configuration registers.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brk_w       <= bwtg_pkg::RST_BRK_W;
            r_cfg.brk_h       <= bwtg_pkg::RST_BRK_H;
            r_cfg.joint_color <= bwtg_pkg::RST_JOINT_COLOR;
            r_cfg.brk_rgb     <= bwtg_pkg::RST_BRK_RGB;
            r_cfg.light_base  <= bwtg_pkg::RST_LIGHT_BASE;
            r_cfg.light_vary  <= bwtg_pkg::RST_LIGHT_VARY;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                bwtg_pkg::REG_BRK_W: begin
                    r_cfg.brk_w <= i_cfg.data[bwtg_pkg::DIM_W-1:0];
                end
                bwtg_pkg::REG_BRK_H: begin
                    r_cfg.brk_h <= i_cfg.data[bwtg_pkg::DIM_W-1:0];
                end
                bwtg_pkg::REG_JOINT_COLOR: begin
                    r_cfg.joint_color <= i_cfg.data[bwtg_pkg::COLOR_W-1:0];
                end
                bwtg_pkg::REG_BRK_RGB: begin
                    r_cfg.brk_rgb <= i_cfg.data[bwtg_pkg::COLOR_W-1:0];
                end
                bwtg_pkg::REG_LIGHT_BASE: begin
                    r_cfg.light_base <= $signed(i_cfg.data[bwtg_pkg::LIGHT_W-1:0]);
                end
                bwtg_pkg::REG_LIGHT_VARY: begin
                    r_cfg.light_vary <= $signed(i_cfg.data[bwtg_pkg::LIGHT_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // Brick row, column and mortar flag.
    bwtg_coord u_coord (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_coord.valid),
        .o_ready (i_coord.ready),
        .i_tex_x (i_coord.tex_x),
        .i_tex_y (i_coord.tex_y),
        .o_valid (cell_valid),
        .i_ready (cell_ready),
        .o_cell  (loc)
    );

    // Per-brick noise.
    bwtg_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cell_valid),
        .o_ready (cell_ready),
        .i_cell  (loc),
        .o_valid (noise_valid),
        .i_ready (noise_ready),
        .o_noise (noise)
    );

    // Shading and final color.
    bwtg_shade u_shade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (noise_valid),
        .o_ready (noise_ready),
        .i_noise (noise),
        .o_valid (o_color.valid),
        .i_ready (o_color.ready),
        .o_color (o_color.texel_color)
    );

endmodule

### dv/texel_color_checker.sv
// Checker of the brick texel unit: tracks the registers, predicts each texel color and compares.
module texel_color_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    bwtg_coord_if  coord,
    bwtg_color_if  color,
    bwtg_cfg_if    cfg,
    output int     o_fail_count,
    output int     o_pending
);

    localparam int HW = bwtg_pkg::HASH_W;

    // Local copy of the configuration registers.
    logic [bwtg_pkg::DIM_W-1:0]          brk_w;
    logic [bwtg_pkg::DIM_W-1:0]          brk_h;
    logic [bwtg_pkg::COLOR_W-1:0]        joint_color;
    logic [bwtg_pkg::COLOR_W-1:0]        brk_rgb;
    logic signed [bwtg_pkg::LIGHT_W-1:0] light_base;
    logic signed [bwtg_pkg::LIGHT_W-1:0] light_vary;

    // Colors predicted for accepted coordinates, oldest first.
    logic [bwtg_pkg::COLOR_W-1:0] expected_colors[$];

    int mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    // Color of one texel under the current registers.
    function automatic logic [bwtg_pkg::COLOR_W-1:0] shade_texel(
        input logic [bwtg_pkg::COORD_W-1:0] x,
        input logic [bwtg_pkg::COORD_W-1:0] y);
        int unsigned                  w;
        int unsigned                  h;
        int unsigned                  row;
        int unsigned                  col;
        int unsigned                  sx;
        logic [HW-1:0]                n;
        longint                       num;
        longint                       ch;
        longint                       part;
        logic [bwtg_pkg::COLOR_W-1:0] shaded;
        // A zero dimension counts as one texel.
        w   = (brk_w == '0) ? 1 : brk_w;
        h   = (brk_h == '0) ? 1 : brk_h;
        row = y / h;
        // Odd rows are offset by half a brick.
        sx  = x + ((row % 2 == 1) ? w / 2 : 0);
        col = sx / w;
        if ((y % h == 0) || (sx % w == 0)) begin
            return joint_color;
        end
        // Per-brick hash with wrapping 32-bit multiplies; the top half is the noise.
        n   = HW'(col) * bwtg_pkg::HASH_MX + HW'(row) * bwtg_pkg::HASH_MY;
        n   = (n ^ (n >> 13)) * bwtg_pkg::HASH_MIX;
        num = longint'($signed(light_base)) * 65535
            + longint'($signed(light_vary)) * longint'(n[31:16]);
        shaded = '0;
        for (int k = 0; k < 3; k++) begin
            ch = longint'(brk_rgb[8*k +: 8]);
            if (num <= 0) begin
                part = 0;
            end else if (num >= bwtg_pkg::LIGHT_DEN) begin
                part = ch;
            end else begin
                part = (ch * num) / bwtg_pkg::LIGHT_DEN;
            end
            shaded[8*k +: 8] = 8'(part);
        end
        return shaded;
    endfunction

    // Compare results, predict new items, then apply register writes.
    always @(posedge i_clk) begin
        logic [bwtg_pkg::COLOR_W-1:0] want;
        if (!i_rst_n) begin
            brk_w       = bwtg_pkg::RST_BRK_W;
            brk_h       = bwtg_pkg::RST_BRK_H;
            joint_color = bwtg_pkg::RST_JOINT_COLOR;
            brk_rgb     = bwtg_pkg::RST_BRK_RGB;
            light_base  = bwtg_pkg::RST_LIGHT_BASE;
            light_vary  = bwtg_pkg::RST_LIGHT_VARY;
            expected_colors.delete();
        end else begin
            if (color.valid && color.ready) begin
                if (expected_colors.size() == 0) begin
                    mismatch_count++;
                    $error("texel_color: no item expected, actual %06h", color.texel_color);
                end else begin
                    want = expected_colors.pop_front();
                    if (color.texel_color !== want) begin
                        mismatch_count++;
                        $error("texel_color: expected %06h, actual %06h",
                               want, color.texel_color);
                    end
                end
            end
            if (coord.valid && coord.ready) begin
                expected_colors.push_back(shade_texel(coord.tex_x, coord.tex_y));
            end
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    bwtg_pkg::REG_BRK_W:       brk_w       = cfg.data[bwtg_pkg::DIM_W-1:0];
                    bwtg_pkg::REG_BRK_H:       brk_h       = cfg.data[bwtg_pkg::DIM_W-1:0];
                    bwtg_pkg::REG_JOINT_COLOR: joint_color = cfg.data[bwtg_pkg::COLOR_W-1:0];
                    bwtg_pkg::REG_BRK_RGB:     brk_rgb     = cfg.data[bwtg_pkg::COLOR_W-1:0];
                    bwtg_pkg::REG_LIGHT_BASE:  light_base  = cfg.data[bwtg_pkg::LIGHT_W-1:0];
                    bwtg_pkg::REG_LIGHT_VARY:  light_vary  = cfg.data[bwtg_pkg::LIGHT_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending <= expected_colors.size();
    end

endmodule

### dv/testbench.sv
// Top of the brick texel unit testbench: clock, reset, coordinate and register stimulus, verdict.
module testbench;

    localparam int XW  = bwtg_pkg::COORD_W;
    localparam int IW  = bwtg_pkg::CFG_IDX_W;
    localparam int CDW = bwtg_pkg::CFG_DATA_W;

    // Register indexes past the list; writes there must leave every register alone.
    localparam logic [IW-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IW-1:0] REG_SPARE_HI = 3'd7;

    localparam int RANDOM_PHASES    = 12;
    localparam int ITEMS_PER_PHASE  = 75;
    localparam int SETTLE_CYCLES    = 20;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int fail_count;
    int pending;

    // Idle pattern state of the sender and the receiver.
    int tx_run  = 0;
    bit tx_calm = 1'b0;
    int rx_run  = 0;
    bit rx_calm = 1'b0;

    bwtg_coord_if coord_ch ();
    bwtg_color_if color_ch ();
    bwtg_cfg_if   cfg_ch ();

    brick_wall_texel_generator_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coord (coord_ch),
        .o_color (color_ch),
        .i_cfg   (cfg_ch)
    );

    texel_color_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .coord        (coord_ch),
        .color        (color_ch),
        .cfg          (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Idle cycles before the next item; each run of items is randomly busy or quiet.
    task automatic draw_idle(inout int run, inout bit calm, output int n_idle);
        if (run == 0) begin
            run  = $urandom_range(8, 48);
            calm = ($urandom_range(0, 3) == 0);
        end
        run--;
        n_idle = calm ? 0 : $urandom_range(0, 15);
    endtask

    // Offer one coordinate and wait until it is taken.
    task automatic send_texel(input logic [XW-1:0] x, input logic [XW-1:0] y);
        int n_idle;
        draw_idle(tx_run, tx_calm, n_idle);
        if (n_idle > 0) begin
            coord_ch.valid <= 1'b0;
            repeat (n_idle) @(posedge i_clk);
        end
        coord_ch.valid <= 1'b1;
        coord_ch.tex_x <= x;
        coord_ch.tex_y <= y;
        @(posedge i_clk);
        while (!coord_ch.ready) @(posedge i_clk);
    endtask

    // Stop sending and wait until every predicted color has come back.
    task automatic await_drain();
        coord_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IW-1:0]  idx,
                             input logic [CDW-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
    endtask

    // Write all six registers back to back.
    task automatic set_config(input logic [CDW-1:0] w, input logic [CDW-1:0] h,
                              input logic [CDW-1:0] jc, input logic [CDW-1:0] bc,
                              input logic [CDW-1:0] lb, input logic [CDW-1:0] lv);
        write_reg(bwtg_pkg::REG_BRK_W, w);
        write_reg(bwtg_pkg::REG_BRK_H, h);
        write_reg(bwtg_pkg::REG_JOINT_COLOR, jc);
        write_reg(bwtg_pkg::REG_BRK_RGB, bc);
        write_reg(bwtg_pkg::REG_LIGHT_BASE, lb);
        write_reg(bwtg_pkg::REG_LIGHT_VARY, lv);
        cfg_ch.valid <= 1'b0;
    endtask

    // Light value inside the nominal range, or any word at all now and then.
    function automatic logic [CDW-1:0] pick_light();
        if ($urandom_range(0, 3) == 0) begin
            return CDW'($urandom());
        end
        return CDW'($urandom_range(0, 262144)) - CDW'(131072);
    endfunction

    // Brick size: mostly the nominal range, sometimes any 7-bit value.
    function automatic logic [CDW-1:0] pick_dim(input int lo);
        if ($urandom_range(0, 3) == 0) begin
            return CDW'($urandom());
        end
        return CDW'($urandom_range(lo, 64));
    endfunction

    // Receiver: accepts colors with random stalls.
    initial begin
        int n_idle;
        color_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            draw_idle(rx_run, rx_calm, n_idle);
            if (n_idle > 0) begin
                color_ch.ready <= 1'b0;
                repeat (n_idle) @(posedge i_clk);
            end
            color_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!color_ch.valid) @(posedge i_clk);
        end
    end

    // Stimulus and verdict.
    initial begin
        logic [XW-1:0] px;
        logic [XW-1:0] py;
        i_rst_n        <= 1'b0;
        coord_ch.valid <= 1'b0;
        coord_ch.tex_x <= '0;
        coord_ch.tex_y <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= '0;
        cfg_ch.data    <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: corners, mortar rows and columns, shifted rows, brick interiors.
        send_texel(6'd0, 6'd0);
        send_texel(6'd63, 6'd63);
        send_texel(6'd63, 6'd0);
        send_texel(6'd0, 6'd63);
        send_texel(6'd1, 6'd1);
        send_texel(6'd8, 6'd9);
        send_texel(6'd9, 6'd9);
        send_texel(6'd7, 6'd8);
        send_texel(6'd37, 6'd21);

        // Zero brick sizes act as one: all mortar. Spare indexes must change nothing.
        await_drain();
        write_reg(REG_SPARE_LO, 24'hFFFFFF);
        write_reg(REG_SPARE_HI, 24'h000001);
        set_config(24'd0, 24'd0, 24'h123456, 24'hFFFFFF, 24'h020000, 24'h000000);
        send_texel(6'd5, 6'd3);
        send_texel(6'd63, 6'd62);

        // Brick width of one: no shift and all mortar.
        await_drain();
        set_config(24'd1, 24'd64, 24'hABCDEF, 24'hFFFFFF, 24'h020000, 24'h020000);
        send_texel(6'd3, 6'd9);
        send_texel(6'd62, 6'd1);

        // Oversized bricks with the widest light words.
        await_drain();
        set_config(24'hFFFF7F, 24'hFFFF7F, 24'h000000, 24'hFFFFFF, 24'h03FFFF, 24'h040000);
        send_texel(6'd1, 6'd1);
        send_texel(6'd63, 6'd63);
        send_texel(6'd0, 6'd5);

        // Light clamped high: brick color passes through.
        await_drain();
        set_config(24'd2, 24'd2, 24'h000000, 24'hFFFFFF, 24'h020000, 24'h000000);
        send_texel(6'd1, 6'd1);
        send_texel(6'd2, 6'd3);
        send_texel(6'd63, 6'd63);

        // Light clamped low, and largest nominal brick.
        await_drain();
        set_config(24'd64, 24'd64, 24'hFFFFFF, 24'hFFFFFF, 24'hFE0000, 24'h020000);
        send_texel(6'd1, 6'd1);
        send_texel(6'd63, 6'd63);
        send_texel(6'd0, 6'd17);

        // Random phases; each starts from an idle block with fresh registers.
        px = '0;
        py = '0;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            await_drain();
            if ($urandom_range(0, 3) == 0) begin
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                          CDW'($urandom()));
            end
            set_config(pick_dim(2), pick_dim(1), CDW'($urandom()),
                       CDW'($urandom()), pick_light(), pick_light());
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // Half the texels continue a raster scan, the rest jump anywhere.
                if ($urandom_range(0, 1) == 0) begin
                    px = XW'($urandom());
                    py = XW'($urandom());
                end else begin
                    px = px + 1'b1;
                    if (px == '0) begin
                        py = py + 1'b1;
                    end
                end
                send_texel(px, py);
            end
        end

        await_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #10000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
